@@ rtl/core/dpfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpfc_pkg: shared types and codes for the dedup packet FIFO
// Entry layout, broadcast query bundle, per-cell control and operation codes.
// ----------------------------------------------------------------------------
package dpfc_pkg;

  // Operation codes carried on in_op
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_FWD = 2'd1;
  localparam logic [1:0] OP_CNT = 2'd2;

  // Width of the configuration register and of the saturated count
  localparam int unsigned LIMIT_W  = 7;
  localparam int unsigned COUNT_W  = 7;
  localparam logic [COUNT_W-1:0] COUNT_SAT = 7'd127;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd64;

  // One held packet: source in the top 16 bits, then destination, then stamp
  typedef struct packed {
    logic [15:0] src;
    logic [15:0] dest;
    logic [31:0] stamp;
  } entry_t;

  // Query broadcast to every cell at accept
  typedef struct packed {
    entry_t      word;
    logic [31:0] first;
    logic [31:0] last;
  } query_t;

  // Per-cell move controls
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

@@ rtl/core/dpfc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpfc_cell: one slot of the packet chain
// Holds one packet, takes its neighbor's packet on a pop, loads a new one on
// an append, and registers its duplicate and range-match flags at accept.
// ----------------------------------------------------------------------------
module dpfc_cell
  import dpfc_pkg::*;
(
  input  logic       clk,
  input  logic       cap,
  input  query_t     q,
  input  logic       live,
  input  cell_ctrl_t ctrl,
  input  entry_t     new_word,
  input  entry_t     nbr_word,
  output entry_t     word_o,
  output logic       dup_o,
  output logic       hit_o
);

  entry_t word_r;
  logic   dup_r;
  logic   hit_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      word_r <= new_word;
    end else if (ctrl.shift) begin
      word_r <= nbr_word;
    end
  end

  // sample match flags against the query that is being accepted
  always_ff @(posedge clk) begin
    if (cap) begin
      dup_r <= live && (q.word == word_r);
      hit_r <= live && (q.word.dest == word_r.dest) &&
               (word_r.stamp >= q.first) && (word_r.stamp <= q.last);
    end
  end

  assign word_o = word_r;
  assign dup_o  = dup_r;
  assign hit_o  = hit_r;

endmodule

@@ rtl/core/dpfc_count.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpfc_count: range-match counter
// Popcounts the cell hit flags in groups of eight, then drains the group sums
// eight per cycle through a shift line into an accumulator.
// ----------------------------------------------------------------------------
module dpfc_count #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned CW    = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic [DEPTH-1:0] hits,
  output logic             busy,
  output logic [CW-1:0]    total
);

  localparam int unsigned NG  = (DEPTH + 7) / 8;
  localparam int unsigned NP  = (NG + 7) / 8;
  localparam int unsigned NGA = NP * 8;
  localparam int unsigned PW  = $clog2(NP + 1);

  logic [NGA*8-1:0] hits_pad;
  logic [3:0]       pc     [NGA];
  logic [3:0]       grp_r  [NGA];
  logic [3:0]       grp_nxt[NGA];
  logic [6:0]       sum8;
  logic [CW-1:0]    acc_r;
  logic [PW-1:0]    pass_r;

  assign hits_pad = (NGA*8)'(hits);

  for (genvar g = 0; g < NGA; g++) begin : g_grp
    always_comb begin
      pc[g] = 4'd0;
      for (int k = 0; k < 8; k++) begin
        pc[g] = pc[g] + 4'(hits_pad[g*8+k]);
      end
    end
    if (g + 8 < NGA) begin : g_sh
      assign grp_nxt[g] = grp_r[g+8];
    end else begin : g_end
      assign grp_nxt[g] = 4'd0;
    end
  end

  // add the eight group sums at the head of the line
  always_comb begin
    sum8 = 7'd0;
    for (int k = 0; k < 8; k++) begin
      sum8 = sum8 + 7'(grp_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r <= '0;
    end else if (load) begin
      pass_r <= PW'(NP);
    end else if (pass_r != '0) begin
      pass_r <= pass_r - PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= pc;
      acc_r <= '0;
    end else if (pass_r != '0) begin
      grp_r <= grp_nxt;
      acc_r <= acc_r + CW'(sum8);
    end
  end

  assign busy  = (pass_r != '0);
  assign total = acc_r;

endmodule

@@ rtl/core/dedup_packet_fifo_with_range_count.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dedup_packet_fifo_with_range_count: bounded packet FIFO, duplicate filter
// Packets sit oldest-first in a chain of cells. Every cell compares its
// packet against the accepted word in parallel; pops shift the chain.
//
// Timing: add, forward and unknown ops raise out_valid from EXEC once the
//   result slot is free (the cell compares register at the accept edge); a
//   count loads the counter in EXEC, drains it in SUM, then raises out_valid
//   once the drain ends and the result slot is free.
// Throughput: one word at a time; the next word is accepted back in IDLE.
// Reset: synchronous active-low; queue empty, head at cell 0, limit 64.
// ----------------------------------------------------------------------------
module dedup_packet_fifo_with_range_count
  import dpfc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_we,
  input  logic [LIMIT_W-1:0]  cfg_wdata,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_op,
  input  logic [15:0]         in_source_id,
  input  logic [15:0]         in_dest_id,
  input  logic [31:0]         in_stamp,
  input  logic [31:0]         in_range_first,
  input  logic [31:0]         in_range_last,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_ok,
  output logic [15:0]         out_source,
  output logic [15:0]         out_dest,
  output logic [31:0]         out_stamp,
  output logic [COUNT_W-1:0]  out_match_count
);

  // occupancy needs to hold QUEUE_DEPTH itself
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SUM
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      occ_r, occ_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic [1:0]         op_r, op_nxt;
  entry_t             new_r, new_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_ok_r, out_ok_nxt;
  entry_t             out_word_r, out_word_nxt;
  logic [COUNT_W-1:0] out_cnt_r, out_cnt_nxt;

  query_t             in_q;
  logic               in_accept;
  logic               slot_free;
  logic               is_dup;
  logic [LW-1:0]      lim_eff;
  logic [LW-1:0]      occ_ext;
  logic [LW-1:0]      acc_ext;
  logic               pop;
  logic               push;
  logic [CW-1:0]      wpos;
  logic               cnt_load;
  logic               cnt_busy;
  logic [CW-1:0]      cnt_total;

  entry_t             cell_word[QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] dup_bits;
  logic [QUEUE_DEPTH-1:0] hit_bits;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  assign in_q.word.src   = in_source_id;
  assign in_q.word.dest  = in_dest_id;
  assign in_q.word.stamp = in_stamp;
  assign in_q.first      = in_range_first;
  assign in_q.last       = in_range_last;

  // --------------------------------------------------------------------------
  // Cell chain: cell 0 holds the oldest packet, cell occ-1 the newest.
  // A pop shifts every cell one place toward the head; an append loads the
  // first free cell after that shift.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_ctrl_t ctrl;
    entry_t     nbr;

    assign ctrl.shift = pop;
    assign ctrl.load  = push && (wpos == CW'(i));

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nbr = cell_word[i];
    end else begin : g_mid
      assign nbr = cell_word[i+1];
    end

    dpfc_cell u_cell (
      .clk      (clk),
      .cap      (in_accept),
      .q        (in_q),
      .live     (occ_r > CW'(i)),
      .ctrl     (ctrl),
      .new_word (new_r),
      .nbr_word (nbr),
      .word_o   (cell_word[i]),
      .dup_o    (dup_bits[i]),
      .hit_o    (hit_bits[i])
    );
  end

  dpfc_count #(
    .DEPTH (QUEUE_DEPTH),
    .CW    (CW)
  ) u_count (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (cnt_load),
    .hits  (hit_bits),
    .busy  (cnt_busy),
    .total (cnt_total)
  );

  assign is_dup  = |dup_bits;
  assign occ_ext = LW'(occ_r);
  assign acc_ext = LW'(cnt_total);

  // clamp the limit into 1..QUEUE_DEPTH
  always_comb begin
    if (limit_r == '0) begin
      lim_eff = LW'(1);
    end else if (LW'(limit_r) > LW'(QUEUE_DEPTH)) begin
      lim_eff = LW'(QUEUE_DEPTH);
    end else begin
      lim_eff = LW'(limit_r);
    end
  end

  // --------------------------------------------------------------------------
  // Control: accept in IDLE, act in EXEC once the result slot is free, and
  // wait out the count drain in SUM.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    op_nxt        = op_r;
    new_nxt       = new_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ok_nxt    = out_ok_r;
    out_word_nxt  = out_word_r;
    out_cnt_nxt   = out_cnt_r;
    pop           = 1'b0;
    push          = 1'b0;
    wpos          = occ_r;
    cnt_load      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          op_nxt    = in_op;
          new_nxt   = in_q.word;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (op_r == OP_CNT) begin
          // start the drain; the result goes out from SUM
          cnt_load  = 1'b1;
          state_nxt = ST_SUM;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b0;
          out_word_nxt  = '0;
          out_cnt_nxt   = '0;
          state_nxt     = ST_IDLE;
          case (op_r)
            OP_ADD: begin
              if (!is_dup) begin
                // evict the oldest first when at or over the limit
                pop        = (occ_ext >= lim_eff);
                push       = 1'b1;
                wpos       = pop ? (occ_r - CW'(1)) : occ_r;
                occ_nxt    = pop ? occ_r : (occ_r + CW'(1));
                out_ok_nxt = 1'b1;
              end
            end
            OP_FWD: begin
              if (occ_r != '0) begin
                pop          = 1'b1;
                occ_nxt      = occ_r - CW'(1);
                out_ok_nxt   = 1'b1;
                out_word_nxt = cell_word[0];
              end
            end
            default: begin
              // unknown op: all-zero result, no state change
            end
          endcase
        end
      end

      ST_SUM: begin
        if (!cnt_busy && slot_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b0;
          out_word_nxt  = '0;
          out_cnt_nxt   = (acc_ext > LW'(COUNT_SAT)) ? COUNT_SAT : acc_ext[COUNT_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      limit_r     <= LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
    op_r       <= op_nxt;
    new_r      <= new_nxt;
    out_ok_r   <= out_ok_nxt;
    out_word_r <= out_word_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_source      = out_word_r.src;
  assign out_dest        = out_word_r.dest;
  assign out_stamp       = out_word_r.stamp;
  assign out_match_count = out_cnt_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");

  a_fwd_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && op_r == OP_FWD && slot_free && occ_r != '0)
      |=> (occ_r == $past(occ_r) - CW'(1)))
    else $error("forward did not retire one packet");

  a_add_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && op_r == OP_ADD && slot_free && !is_dup)
      |=> (occ_r != '0) && out_ok)
    else $error("accepted add left queue empty");

  a_drain_in_sum: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_busy |-> (state_r == ST_SUM))
    else $error("count drain running outside SUM");

endmodule
